FILE: sv/mexp_pkg.sv
package mexp_pkg;

    // Default operand width and the fixed width of the item fields.
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH       = 32;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] base;
        logic [FIELD_WIDTH-1:0] exponent;
        logic [FIELD_WIDTH-1:0] modulus;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] power_result;
        logic                   modulus_zero_error;
    } t_out_item;

    // Status of the serial modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    // Status of the exponentiation sequencer towards the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MULT,
        S_SQUARE,
        S_DONE
    } t_state;

endpackage

FILE: sv/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: r = (x * y) mod m, one bit of y
// per cycle, most significant bit first. Requires x <= m and m nonzero.
module mexp_modmul #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_x,
    input  logic [OPERAND_WIDTH-1:0] i_y,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    output logic [OPERAND_WIDTH-1:0] o_result,
    output mexp_pkg::t_mul_stat      o_stat
);

    localparam int CW = $clog2(OPERAND_WIDTH + 1);

    logic [OPERAND_WIDTH-1:0] r_r, n_r;
    logic [OPERAND_WIDTH-1:0] r_x;
    logic [OPERAND_WIDTH-1:0] r_y;
    logic [OPERAND_WIDTH-1:0] r_m;
    logic [CW-1:0]            r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [OPERAND_WIDTH:0]   dbl;
    logic [OPERAND_WIDTH:0]   dbl_red;
    logic [OPERAND_WIDTH:0]   sum;
    logic [OPERAND_WIDTH:0]   m_ext;

    // Double the partial remainder, then add x when the current bit of y is set;
    // each step stays below twice the modulus, so one subtraction suffices.
    always_comb begin
        m_ext   = {1'b0, r_m};
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (r_y[OPERAND_WIDTH-1] ? {1'b0, r_x} : '0);
        n_r     = (sum >= m_ext) ? OPERAND_WIDTH'(sum - m_ext) : sum[OPERAND_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(OPERAND_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= '0;
            r_x <= i_x;
            r_y <= i_y;
            r_m <= i_m;
        end else if (r_busy) begin
            r_r <= n_r;
            r_y <= {r_y[OPERAND_WIDTH-2:0], 1'b0};
        end
    end

    assign o_result    = r_r;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: sv/mexp_seq.sv
// Square-and-multiply sequencer: scans the exponent from its least significant
// bit and issues reduce, multiply and square operations to the shared multiplier.
module mexp_seq #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  mexp_pkg::t_in_item       i_item,
    input  logic                     i_out_free,
    input  logic [OPERAND_WIDTH-1:0] i_mul_result,
    input  mexp_pkg::t_mul_stat      i_mul_stat,
    output logic                     o_mul_start,
    output logic [OPERAND_WIDTH-1:0] o_mul_x,
    output logic [OPERAND_WIDTH-1:0] o_mul_y,
    output logic [OPERAND_WIDTH-1:0] o_mul_m,
    output mexp_pkg::t_out_item      o_result,
    output mexp_pkg::t_seq_stat      o_stat
);

    localparam int BW = $clog2(OPERAND_WIDTH);

    mexp_pkg::t_state r_state, n_state;
    logic             r_launch, n_launch;

    logic [OPERAND_WIDTH-1:0] r_acc;
    logic [OPERAND_WIDTH-1:0] r_sq;
    logic [OPERAND_WIDTH-1:0] r_exp;
    logic [OPERAND_WIDTH-1:0] r_mod;
    logic [BW-1:0]            r_bitcnt;
    logic                     r_err;

    logic in_mod_zero;
    logic in_exp_zero;

    assign in_mod_zero = (i_item.modulus[OPERAND_WIDTH-1:0] == '0);
    assign in_exp_zero = (i_item.exponent[OPERAND_WIDTH-1:0] == '0);

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_launch = 1'b0;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                if (i_accept) begin
                    if (in_mod_zero || in_exp_zero) begin
                        n_state = mexp_pkg::S_DONE;
                    end else begin
                        n_state  = mexp_pkg::S_REDUCE;
                        n_launch = 1'b1;
                    end
                end
            end
            mexp_pkg::S_REDUCE: begin
                if (i_mul_stat.done) begin
                    n_state  = r_exp[0] ? mexp_pkg::S_MULT : mexp_pkg::S_SQUARE;
                    n_launch = 1'b1;
                end
            end
            mexp_pkg::S_MULT: begin
                if (i_mul_stat.done) begin
                    n_state  = mexp_pkg::S_SQUARE;
                    n_launch = 1'b1;
                end
            end
            mexp_pkg::S_SQUARE: begin
                if (i_mul_stat.done) begin
                    if (r_bitcnt == BW'(OPERAND_WIDTH - 1)) begin
                        n_state = mexp_pkg::S_DONE;
                    end else begin
                        n_state  = r_exp[1] ? mexp_pkg::S_MULT : mexp_pkg::S_SQUARE;
                        n_launch = 1'b1;
                    end
                end
            end
            mexp_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = mexp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mexp_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and operand selection.
    always_comb begin
        o_mul_start = r_launch;
        o_mul_m     = r_mod;
        o_stat.idle = 1'b0;
        o_stat.done = 1'b0;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                o_mul_x     = r_sq;
                o_mul_y     = r_sq;
                o_stat.idle = 1'b1;
            end
            mexp_pkg::S_REDUCE: begin
                // The base sits in the accumulator; 1 * base mod m reduces it.
                o_mul_x = OPERAND_WIDTH'(1);
                o_mul_y = r_acc;
            end
            mexp_pkg::S_MULT: begin
                o_mul_x = r_sq;
                o_mul_y = r_acc;
            end
            mexp_pkg::S_DONE: begin
                o_mul_x     = r_sq;
                o_mul_y     = r_sq;
                o_stat.done = i_out_free;
            end
            default: begin
                o_mul_x = r_sq;
                o_mul_y = r_sq;
            end
        endcase
        o_result.power_result       = mexp_pkg::FIELD_WIDTH'(r_acc);
        o_result.modulus_zero_error = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mexp_pkg::S_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_exp    <= i_item.exponent[OPERAND_WIDTH-1:0];
            r_mod    <= i_item.modulus[OPERAND_WIDTH-1:0];
            r_bitcnt <= '0;
            r_err    <= in_mod_zero;
            if (in_mod_zero) begin
                r_acc <= '0;
            end else if (in_exp_zero) begin
                r_acc <= OPERAND_WIDTH'(1);
            end else begin
                r_acc <= i_item.base[OPERAND_WIDTH-1:0];
            end
        end else if (i_mul_stat.done) begin
            case (r_state)
                mexp_pkg::S_REDUCE: begin
                    r_sq  <= i_mul_result;
                    r_acc <= OPERAND_WIDTH'(1);
                end
                mexp_pkg::S_MULT: begin
                    r_acc <= i_mul_result;
                end
                mexp_pkg::S_SQUARE: begin
                    r_sq     <= i_mul_result;
                    r_exp    <= {1'b0, r_exp[OPERAND_WIDTH-1:1]};
                    r_bitcnt <= r_bitcnt + BW'(1);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: sv/modular_exponentiation_core.sv
// Channel | Direction | Handshake                       | Item
// in      | to core   | i_in_valid, o_in_stall          | base, exponent, modulus
// out     | from core | o_out_valid, i_out_stall        | power_result, modulus_zero_error
//
// One item is worked on at a time. A zero modulus or a zero exponent is answered
// straight from the sequencer, without the multiplier. Otherwise each modular
// operation runs on the single bit-serial multiplier, and an item needs one
// reduction, OPERAND_WIDTH squarings and one multiplication per set exponent
// bit. Reset is synchronous and active low; it clears the control state only.
// A finished result waits in the output register while the sequencer takes the
// next item; the sequencer then holds its own finished result, with the input
// stalled, until the output register is free again.
module modular_exponentiation_core #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mexp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mexp_pkg::t_out_item o_out_item
);

    logic                     in_accept;
    logic                     out_free;
    logic                     mul_start;
    logic [OPERAND_WIDTH-1:0] mul_x;
    logic [OPERAND_WIDTH-1:0] mul_y;
    logic [OPERAND_WIDTH-1:0] mul_m;
    logic [OPERAND_WIDTH-1:0] mul_result;
    mexp_pkg::t_mul_stat      mul_stat;
    mexp_pkg::t_seq_stat      seq_stat;
    mexp_pkg::t_out_item      seq_result;

    logic                     r_out_valid;
    mexp_pkg::t_out_item      r_out_item;

    // The input side is open only while the sequencer is idle.
    assign o_in_stall = !seq_stat.idle;
    assign in_accept  = i_in_valid && seq_stat.idle;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    mexp_seq #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .i_out_free   (out_free),
        .i_mul_result (mul_result),
        .i_mul_stat   (mul_stat),
        .o_mul_start  (mul_start),
        .o_mul_x      (mul_x),
        .o_mul_y      (mul_y),
        .o_mul_m      (mul_m),
        .o_result     (seq_result),
        .o_stat       (seq_stat)
    );

    mexp_modmul #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_x      (mul_x),
        .i_y      (mul_y),
        .i_m      (mul_m),
        .o_result (mul_result),
        .o_stat   (mul_stat)
    );

    // Output register: loaded when the sequencer hands over a finished item,
    // emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            r_out_item <= seq_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // Once an item is taken, the input stays closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // The multiplier is only launched when it is free.
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier launched while busy");

    // A multiplier result never arrives while the sequencer is idle.
    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> !seq_stat.idle)
        else $error("multiplier finished with no item in progress");

    // An error result always carries a zero value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.modulus_zero_error) |-> (o_out_item.power_result == '0))
        else $error("error result with nonzero value");
`endif

endmodule

FILE: tb/sv/modular_exponentiation_core_tb.sv
module modular_exponentiation_core_tb;

    // The block is built with its default operand width, so the model of it below
    // scans the same number of exponent bits.
    localparam int          OP_W         = mexp_pkg::OPERAND_WIDTH_DEF;
    localparam int          RANDOM_ITEMS = 250;
    localparam int          HOLD_CYCLES  = 6000;
    // The slowest run is roughly 280 items on the longest path, plus sender gaps,
    // receiver stalls and the long hold-off. This limit is about four times that.
    localparam longint      RUN_LIMIT    = 64'd24_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    mexp_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    mexp_pkg::t_out_item o_out_item;

    // Results still owed by the block, oldest first.
    mexp_pkg::t_out_item owed_powers[$];
    int unsigned         error_count;
    // Sender burst state. While steady_sender is set, items follow back to back.
    int unsigned         burst_left;
    bit                  steady_sender;
    // Written by a test, counted down by the receiver process.
    int unsigned         hold_off_request;

    modular_exponentiation_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("modular_exponentiation_core test failed");
        $finish;
    end

    // Right-to-left square-and-multiply. The base is reduced first; a zero
    // modulus is flagged, and a zero exponent answers 1 even for a modulus of one.
    function automatic mexp_pkg::t_out_item modular_power(mexp_pkg::t_in_item item);
        logic [63:0]         mask;
        logic [63:0]         expo;
        logic [63:0]         modv;
        logic [63:0]         sq;
        logic [63:0]         acc;
        mexp_pkg::t_out_item res;
        mask = (64'd1 << OP_W) - 64'd1;
        expo = {32'd0, item.exponent} & mask;
        modv = {32'd0, item.modulus} & mask;
        res  = '0;
        if (modv == 64'd0) begin
            res.modulus_zero_error = 1'b1;
        end else if (expo == 64'd0) begin
            res.power_result = 32'd1;
        end else begin
            sq  = ({32'd0, item.base} & mask) % modv;
            acc = 64'd1;
            for (int i = 0; i < OP_W; i++) begin
                if (expo[i]) begin
                    acc = (acc * sq) % modv;
                end
                sq = (sq * sq) % modv;
            end
            res.power_result = acc[31:0];
        end
        return res;
    endfunction

    function automatic mexp_pkg::t_in_item make_item(logic [31:0] b, logic [31:0] e,
                                                     logic [31:0] m);
        mexp_pkg::t_in_item item;
        item.base     = b;
        item.exponent = e;
        item.modulus  = m;
        return item;
    endfunction

    // Offers one item from the falling edge and holds it until the block takes
    // it. Valid is left high afterwards so that a following item comes straight
    // on; at the end of a burst the sender goes quiet for a random gap.
    task automatic send_item(mexp_pkg::t_in_item item);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        owed_powers.insert(owed_powers.size(), modular_power(item));
        if (!steady_sender) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 6);
            end
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        release_input();
        wait (owed_powers.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Draws an item whose modulus covers zero, one, small and full-range values
    // and whose exponent is sometimes short, so that both quick and long paths
    // through the block are exercised.
    function automatic mexp_pkg::t_in_item random_item();
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] m;
        int unsigned pick;
        b    = $urandom;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            e = 32'd0;
        end else if (pick < 5) begin
            e = $urandom_range(1, 255);
        end else begin
            e = $urandom;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            m = 32'd0;
        end else if (pick == 1) begin
            m = 32'd1;
        end else if (pick < 6) begin
            m = $urandom_range(2, 255);
        end else begin
            m = $urandom;
        end
        return make_item(b, e, m);
    endfunction

    task automatic test_special_cases();
        // Zero modulus, whatever the other operands are.
        send_item(make_item(32'd5, 32'd3, 32'd0));
        send_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
        send_item(make_item(32'd9, 32'd0, 32'd0));
        // Zero exponent answers 1, also for a modulus of one.
        send_item(make_item(32'd7, 32'd0, 32'd1));
        send_item(make_item(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
        // Nonzero exponent with a modulus of one.
        send_item(make_item(32'd5, 32'd5, 32'd1));
        send_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
        // The base is not below the modulus, or equals it.
        send_item(make_item(32'hFFFF_FFFF, 32'd3, 32'd1000));
        send_item(make_item(32'd97, 32'd2, 32'd97));
        release_input();
    endtask

    task automatic test_operand_extremes();
        send_item(make_item(32'd0, 32'd1, 32'd13));
        send_item(make_item(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(32'd3, 32'h8000_0000, 32'hFFFF_FFFB));
        send_item(make_item(32'h1234_5678, 32'd1, 32'h7FFF_FFFF));
        send_item(make_item($urandom | 32'd1, $urandom, 32'd2));
        send_item(make_item(32'd3, 32'h0123_4567, 32'h8000_0000));
        send_item(make_item(32'd2, 32'd31, 32'hFFFF_FFFF));
        send_item(make_item(32'hDEAD_BEEF, 32'hAAAA_AAAA, 32'hFFFF_FFFE));
        send_item(make_item(32'h5555_5555, 32'h5555_5555, 32'hFFFF_FFC5));
        release_input();
    endtask

    task automatic test_random_items();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Switch between bursty and back-to-back sending now and then.
            if (n % 40 == 0) begin
                steady_sender = ($urandom_range(0, 2) == 0);
            end
            send_item(random_item());
        end
        steady_sender = 1'b0;
        release_input();
    endtask

    // The receiver refuses results for a long stretch while items keep coming,
    // so the result waits in the output register and the input stalls behind it.
    task automatic test_output_hold_off();
        @(posedge i_clk);
        hold_off_request = HOLD_CYCLES;
        steady_sender    = 1'b1;
        repeat (5) begin
            send_item(random_item());
        end
        steady_sender = 1'b0;
        wait_until_drained();
    endtask

    // The sender stops until every owed result is back, then resumes.
    task automatic test_pause_until_drained();
        repeat (3) begin
            send_item(random_item());
        end
        wait_until_drained();
        repeat (3) begin
            send_item(random_item());
        end
        release_input();
    endtask

    // Receiver: its own stall pattern, switching at random between never stalling,
    // stalling now and then and stalling most of the time. A requested hold-off
    // overrides the pattern and is counted down here.
    initial begin : receiver
        int unsigned mode;
        int unsigned span;
        mode        = 0;
        span        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request > 0) begin
                i_out_stall <= 1'b1;
                hold_off_request--;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(500, 5000);
                end
                span--;
                case (mode)
                    0: begin
                        i_out_stall <= 1'b0;
                    end
                    1: begin
                        i_out_stall <= ($urandom_range(0, 2) == 0);
                    end
                    default: begin
                        i_out_stall <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    // Each accepted result is compared with the oldest owed one.
    always @(posedge i_clk) begin : check_results
        mexp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_powers.size() == 0) begin
                $error("result with none owed: power_result %0h, modulus_zero_error %0b",
                       o_out_item.power_result, o_out_item.modulus_zero_error);
                error_count++;
            end else begin
                want = owed_powers.pop_front();
                if (o_out_item.power_result !== want.power_result) begin
                    $error("power_result: expected %0h, actual %0h",
                           want.power_result, o_out_item.power_result);
                    error_count++;
                end
                if (o_out_item.modulus_zero_error !== want.modulus_zero_error) begin
                    $error("modulus_zero_error: expected %0b, actual %0b",
                           want.modulus_zero_error, o_out_item.modulus_zero_error);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count      = 0;
        burst_left       = 0;
        steady_sender    = 1'b0;
        hold_off_request = 0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in_item        = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_operand_extremes();
        test_output_hold_off();
        test_random_items();
        test_pause_until_drained();

        // Let every owed result arrive, then watch a little longer for strays.
        wait_until_drained();
        repeat (100) @(posedge i_clk);
        if (owed_powers.size() != 0) begin
            $error("%0d results never arrived", owed_powers.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("modular_exponentiation_core test passed");
        end else begin
            $display("modular_exponentiation_core test failed");
        end
        $finish;
    end

endmodule
